>>> hdl/twc_pkg.sv
// Shared types, codes and constants of the text window console.
package twc_pkg;

  // Default screen geometry in character cells.
  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;

  // Fixed field widths.
  localparam int CELL_W     = 16;
  localparam int CELL_IDX_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Transaction function codes.
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_SETC  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIN_COL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_ROW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH      = 3'd4;

  // Configuration reset values.
  localparam logic [6:0] RST_WIN_WIDTH  = 7'd80;
  localparam logic [4:0] RST_WIN_HEIGHT = 5'd25;
  localparam logic [7:0] RST_GLYPH      = 8'd32;

  // Cell attributes and special characters.
  localparam logic [7:0] TEXT_ATTR  = 8'h0F;
  localparam logic [7:0] GLYPH_ATTR = 8'h8F;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] NEWLINE    = 8'h0A;

  // Screen memory write data selects.
  localparam logic [2:0] WSEL_ZERO  = 3'd0;
  localparam logic [2:0] WSEL_BLANK = 3'd1;
  localparam logic [2:0] WSEL_TEXT  = 3'd2;
  localparam logic [2:0] WSEL_GLYPH = 3'd3;
  localparam logic [2:0] WSEL_COPY  = 3'd4;

  // Screen memory write address selects.
  localparam logic [1:0] ASEL_SCAN    = 2'd0;
  localparam logic [1:0] ASEL_SCAN_UP = 2'd1;
  localparam logic [1:0] ASEL_CURSOR  = 2'd2;

  // Screen memory read address selects.
  localparam logic RSEL_INDEX = 1'b0;
  localparam logic RSEL_SCAN  = 1'b1;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]            func;
    logic [7:0]            char_code;
    logic [CELL_IDX_W-1:0] cell_index;
    logic [6:0]            new_col;
    logic [4:0]            new_row;
  } twc_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [6:0]        cur_col;
    logic [4:0]        cur_row;
    logic              scrolled;
  } twc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_sel;
    logic [1:0] addr_sel;
    logic       rd_en;
    logic       rd_sel;
    logic       cap_in;
    logic       scan_start;
    logic       scan_step;
    logic       init_step;
    logic       cur_adv;
    logic       cur_text;
    logic       cur_home;
    logic       cur_load;
    logic       out_load;
  } twc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       nl;
    logic       cur_inside;
    logic       scroll_need;
    logic       wh_one;
    logic       copy_last;
    logic       scan_end;
    logic       init_last;
  } twc_stat_t;

endpackage

>>> hdl/twc_dp.sv
// Datapath of the text window console: screen memory, window, cursor and scan counters.
module twc_dp import twc_pkg::*; #(
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  twc_in_t               in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  twc_cmd_t              cmd,
  output twc_stat_t             stat,
  output twc_out_t              out_data
);

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int SW = $clog2(SCREEN_COLS * (SCREEN_ROWS + 1));
  localparam int CW = ($clog2(SCREEN_COLS) + 1 > 8) ? $clog2(SCREEN_COLS) + 1 : 8;
  localparam int RW = ($clog2(SCREEN_ROWS) + 1 > 6) ? $clog2(SCREEN_ROWS) + 1 : 6;
  localparam int IW = ((AW > CELL_IDX_W) ? AW : CELL_IDX_W) + 1;

  logic [6:0]        win_col_r;
  logic [4:0]        win_row_r;
  logic [6:0]        win_width_r;
  logic [4:0]        win_height_r;
  logic [7:0]        glyph_r;
  twc_in_t           in_r;
  logic [6:0]        cur_col_r;
  logic [4:0]        cur_row_r;
  logic              scrolled_r;
  logic [SW-1:0]     scan_addr_r;
  logic [CW-1:0]     scan_col_r;
  logic [RW-1:0]     scan_row_r;
  logic [CELL_W-1:0] rd_data_r;
  twc_out_t          out_r;
  twc_out_t          out_nxt;

  logic [CW-1:0]     wc;
  logic [CW-1:0]     ww;
  logic [CW-1:0]     ww_req;
  logic [CW-1:0]     col_room;
  logic [RW-1:0]     wr;
  logic [RW-1:0]     wh;
  logic [RW-1:0]     wh_req;
  logic [RW-1:0]     row_room;
  logic [RW-1:0]     last_row;
  logic              nl;
  logic              wrap;
  logic              cur_inside;
  logic [6:0]        adv_col;
  logic [RW-1:0]     adv_row;
  logic              scroll_need;
  logic              col_last;
  logic [RW-1:0]     cur_row_abs;
  logic [SW-1:0]     cursor_addr;
  logic [SW-1:0]     scan_base;
  logic [SW-1:0]     scan_up;
  logic [SW-1:0]     wr_addr_full;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] wr_data;
  logic [IW-1:0]     idx_ext;
  logic              idx_ok;

  logic [CELL_W-1:0] screen_mem [CELL_COUNT];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_col_r    <= '0;
      win_row_r    <= '0;
      win_width_r  <= RST_WIN_WIDTH;
      win_height_r <= RST_WIN_HEIGHT;
      glyph_r      <= RST_GLYPH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_COL:    win_col_r    <= cfg_wdata[6:0];
        REG_WIN_ROW:    win_row_r    <= cfg_wdata[4:0];
        REG_WIN_WIDTH:  win_width_r  <= cfg_wdata[6:0];
        REG_WIN_HEIGHT: win_height_r <= cfg_wdata[4:0];
        REG_GLYPH:      glyph_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective window: origin saturated to the screen, size at least one and cut at the edge.
  always_comb begin
    wc       = (CW'(win_col_r) < CW'(SCREEN_COLS)) ? CW'(win_col_r) : CW'(SCREEN_COLS - 1);
    col_room = CW'(SCREEN_COLS) - wc;
    ww_req   = (win_width_r == '0) ? CW'(1) : CW'(win_width_r);
    ww       = (ww_req > col_room) ? col_room : ww_req;
    wr       = (RW'(win_row_r) < RW'(SCREEN_ROWS)) ? RW'(win_row_r) : RW'(SCREEN_ROWS - 1);
    row_room = RW'(SCREEN_ROWS) - wr;
    wh_req   = (win_height_r == '0) ? RW'(1) : RW'(win_height_r);
    wh       = (wh_req > row_room) ? row_room : wh_req;
    last_row = wh - RW'(1);
  end

  // Captured transaction.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_data;
    end
  end

  // Cursor advance for a put: wrap on newline or past the right edge, scroll past the last row.
  always_comb begin
    nl          = (in_r.char_code == NEWLINE);
    cur_inside  = (CW'(cur_col_r) < ww) && (RW'(cur_row_r) < wh);
    wrap        = nl || (CW'(cur_col_r) >= ww);
    adv_col     = wrap ? '0 : cur_col_r;
    adv_row     = wrap ? RW'(cur_row_r) + RW'(1) : RW'(cur_row_r);
    scroll_need = (adv_row >= wh);
  end

  // Cursor and scroll flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      scrolled_r <= 1'b0;
    end else begin
      if (cmd.cur_home) begin
        cur_col_r <= '0;
        cur_row_r <= '0;
      end else if (cmd.cur_load) begin
        cur_col_r <= in_r.new_col;
        cur_row_r <= in_r.new_row;
      end else if (cmd.cur_adv) begin
        cur_col_r <= adv_col;
        cur_row_r <= scroll_need ? last_row[4:0] : adv_row[4:0];
      end else if (cmd.cur_text) begin
        cur_col_r <= cur_col_r + 7'd1;
      end
      if (cmd.cap_in) begin
        scrolled_r <= 1'b0;
      end else if (cmd.cur_adv && scroll_need) begin
        scrolled_r <= 1'b1;
      end
    end
  end

  // Scan counters. A scan walks source rows from one below the window top; the
  // write lands one screen row higher, so copies move rows up and blanks cover the row above.
  assign scan_base = SW'(wr + RW'(1)) * SW'(SCREEN_COLS) + SW'(wc);
  assign col_last  = (scan_col_r == ww - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      scan_col_r  <= '0;
      scan_row_r  <= '0;
    end else if (cmd.scan_start) begin
      scan_addr_r <= scan_base;
      scan_col_r  <= '0;
      scan_row_r  <= RW'(1);
    end else if (cmd.init_step) begin
      scan_addr_r <= scan_addr_r + SW'(1);
    end else if (cmd.scan_step) begin
      if (col_last) begin
        scan_addr_r <= scan_addr_r + SW'(SCREEN_COLS) + SW'(1) - SW'(ww);
        scan_col_r  <= '0;
        scan_row_r  <= scan_row_r + RW'(1);
      end else begin
        scan_addr_r <= scan_addr_r + SW'(1);
        scan_col_r  <= scan_col_r + CW'(1);
      end
    end
  end

  // Memory addresses and write data.
  always_comb begin
    cur_row_abs = wr + RW'(cur_row_r);
    cursor_addr = SW'(cur_row_abs) * SW'(SCREEN_COLS) + SW'(wc) + SW'(cur_col_r);
    scan_up     = scan_addr_r - SW'(SCREEN_COLS);
    idx_ext     = IW'(in_r.cell_index);
    idx_ok      = (idx_ext < IW'(CELL_COUNT));
    unique case (cmd.addr_sel)
      ASEL_SCAN:    wr_addr_full = scan_addr_r;
      ASEL_SCAN_UP: wr_addr_full = scan_up;
      ASEL_CURSOR:  wr_addr_full = cursor_addr;
      default:      wr_addr_full = scan_addr_r;
    endcase
    wr_addr = wr_addr_full[AW-1:0];
    unique case (cmd.wr_sel)
      WSEL_ZERO:  wr_data = '0;
      WSEL_BLANK: wr_data = {TEXT_ATTR, BLANK_CHAR};
      WSEL_TEXT:  wr_data = {TEXT_ATTR, in_r.char_code};
      WSEL_GLYPH: wr_data = {GLYPH_ATTR, glyph_r};
      WSEL_COPY:  wr_data = rd_data_r;
      default:    wr_data = '0;
    endcase
    unique case (cmd.rd_sel)
      RSEL_INDEX: rd_addr = idx_ext[AW-1:0];
      RSEL_SCAN:  rd_addr = scan_addr_r[AW-1:0];
      default:    rd_addr = scan_addr_r[AW-1:0];
    endcase
  end

  // Screen memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      screen_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= screen_mem[rd_addr];
    end
  end

  // Result register.
  always_comb begin
    out_nxt.cell_data = ((in_r.func == FUNC_READ) && idx_ok) ? rd_data_r : '0;
    out_nxt.cur_col   = cur_col_r;
    out_nxt.cur_row   = cur_row_r;
    out_nxt.scrolled  = scrolled_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.func        = in_r.func;
    stat.nl          = nl;
    stat.cur_inside  = cur_inside;
    stat.scroll_need = scroll_need;
    stat.wh_one      = (wh == RW'(1));
    stat.copy_last   = (scan_row_r == last_row) && col_last;
    stat.scan_end    = (scan_row_r == wh) && col_last;
    stat.init_last   = (scan_addr_r == SW'(CELL_COUNT - 1));
  end

  assign out_data = out_r;

  // Every write must land inside the screen store.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (wr_addr_full < SW'(CELL_COUNT)))
    else $error("screen write outside the store");

  // Only a put transaction may report a scroll.
  a_scroll_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    scrolled_r |-> (in_r.func == FUNC_PUT))
    else $error("scroll flag set on a transaction that is not a put");

endmodule

>>> hdl/twc_ctrl.sv
// Controller state machine of the text window console.
module twc_ctrl import twc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  twc_stat_t stat,
  output twc_cmd_t  cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_HIDE  = 4'd3;
  localparam logic [3:0] S_ADV   = 4'd4;
  localparam logic [3:0] S_CPRD  = 4'd5;
  localparam logic [3:0] S_CPWR  = 4'd6;
  localparam logic [3:0] S_BLANK = 4'd7;
  localparam logic [3:0] S_TEXT  = 4'd8;
  localparam logic [3:0] S_DRAW  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        // Clearing pass over the screen store after reset.
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WSEL_ZERO;
        cmd.addr_sel  = ASEL_SCAN;
        cmd.init_step = 1'b1;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.func) inside
          FUNC_PUT, FUNC_SETC: begin
            state_nxt = S_HIDE;
          end
          FUNC_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RSEL_INDEX;
            state_nxt  = S_DONE;
          end
          FUNC_CLEAR: begin
            cmd.cur_home   = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_BLANK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_HIDE: begin
        // Blank the old cursor cell before anything moves.
        cmd.wr_en    = stat.cur_inside;
        cmd.wr_sel   = WSEL_BLANK;
        cmd.addr_sel = ASEL_CURSOR;
        if (stat.func == FUNC_SETC) begin
          cmd.cur_load = 1'b1;
          state_nxt    = S_DRAW;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        cmd.cur_adv = 1'b1;
        if (stat.scroll_need) begin
          cmd.scan_start = 1'b1;
          state_nxt      = stat.wh_one ? S_BLANK : S_CPRD;
        end else begin
          state_nxt = S_TEXT;
        end
      end
      S_CPRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RSEL_SCAN;
        state_nxt  = S_CPWR;
      end
      S_CPWR: begin
        // Move the cell just read up by one row.
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WSEL_COPY;
        cmd.addr_sel  = ASEL_SCAN_UP;
        cmd.scan_step = 1'b1;
        state_nxt     = stat.copy_last ? S_BLANK : S_CPRD;
      end
      S_BLANK: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WSEL_BLANK;
        cmd.addr_sel  = ASEL_SCAN_UP;
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          state_nxt = (stat.func == FUNC_CLEAR) ? S_DRAW : S_TEXT;
        end
      end
      S_TEXT: begin
        cmd.wr_en    = !stat.nl && stat.cur_inside;
        cmd.wr_sel   = WSEL_TEXT;
        cmd.addr_sel = ASEL_CURSOR;
        cmd.cur_text = !stat.nl;
        state_nxt    = S_DRAW;
      end
      S_DRAW: begin
        cmd.wr_en    = stat.cur_inside;
        cmd.wr_sel   = WSEL_GLYPH;
        cmd.addr_sel = ASEL_CURSOR;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // No cell is written while waiting for a transaction.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd.wr_en)
    else $error("screen write while idle");

  // An accepted transaction is decoded on the next cycle.
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DEC))
    else $error("accepted transaction not decoded");

  // A result only appears at the end of an operation.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the completion state");

endmodule

>>> hdl/text_window_console.sv
// Top level of the text window console: controller and datapath.
//
// The block holds a screen of SCREEN_COLS x SCREEN_ROWS 16-bit cells and a
// text window with its own cursor. One transaction on the input channel
// (in_valid/in_ready, payload in_data) puts a character, reads a cell,
// clears the window or moves the cursor; each gives exactly one result on
// the output channel (out_valid/out_ready, payload out_data). Window and
// cursor glyph are set through cfg_we/cfg_index/cfg_wdata, which the user
// is to write only while idle; the block itself leaves this unenforced.
// One transaction is worked on at a time through a single-write, single-read
// screen memory. A put that scrolls first copies the window rows up by one
// row, reading then writing each cell, and then blanks the new bottom row.
// The next transaction is taken the cycle after the result is registered.
// After reset the store is zeroed one cell a cycle with in_ready low, all
// SCREEN_COLS*SCREEN_ROWS cells (2000 by default); configuration writes
// are taken throughout. A stalled receiver holds the result in the output
// register; a new transaction can still be accepted and is finished up to
// its result, which waits until the earlier one has been taken.
module text_window_console import twc_pkg::*; #(
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  twc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output twc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  twc_cmd_t  cmd;
  twc_stat_t stat;

  // Sequencing of each operation.
  twc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Screen store, window geometry and cursor.
  twc_dp #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
